// ----- design/gn2d_pkg.sv -----
// Shared types and field layout for the 2D gradient noise core.
package gn2d_pkg;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 8;
	localparam int PERM_W  = 8;
	localparam int GRAD_W  = 16;
	localparam int COORD_W = 32;
	localparam int NOISE_W = 16;
	// Corner dot and blend values: Q2.14 plus headroom for |value| <= 2^16
	localparam int DOT_W   = 18;

	// Input tdata layout, lowest bit first
	localparam int IDX_LSB   = 0;
	localparam int PE_LSB    = IDX_LSB + IDX_W;
	localparam int GX_LSB    = PE_LSB + PERM_W;
	localparam int GY_LSB    = GX_LSB + GRAD_W;
	localparam int CX_LSB    = GY_LSB + GRAD_W;
	localparam int CY_LSB    = CX_LSB + COORD_W;
	localparam int IN_DATA_W = CY_LSB + COORD_W;

	localparam logic signed [DOT_W-1:0] SAT_HI = DOT_W'(2 ** (NOISE_W - 1) - 1);
	localparam logic signed [DOT_W-1:0] SAT_LO = DOT_W'(-(2 ** (NOISE_W - 1)));

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_PERM = 2'd0,
		CMD_LOAD_GRAD = 2'd1,
		CMD_EVAL      = 2'd2
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} stage_ctl_t;

endpackage

// ----- design/gradient_noise_2d_core.sv -----
// Top level of the 2D gradient noise core.
//
// Input channel s_*: one item per handshake. s_tuser carries the command:
// load permutation entry, load gradient entry, or evaluate at a Q16.16 point.
// Loads give no result; an evaluate gives one Q2.14 noise item on m_*.
// Both tables must be loaded before an evaluate reads the entries it hashes to.
//
// An evaluate passes the eight internal stages and then the output register
// before its result shows on m_tvalid.
// Throughput: one item per cycle while the output is not stalled, loads and
// evaluates mixed freely; table writes happen at the stage that reads each
// table copy, so they take effect in item order.
//
// All stages advance together. When m_tvalid is high and m_tready low the
// whole pipeline holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits at once; the tables keep no reset value.
module gradient_noise_2d_core #(
	parameter int TABLE_SIZE = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// table_index[7:0], perm_entry[15:8], grad_x[31:16], grad_y[47:32],
	// coord_x[79:48], coord_y[111:80]
	input  logic [gn2d_pkg::IN_DATA_W-1:0]     s_tdata,
	// command[1:0]
	input  logic [gn2d_pkg::CMD_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// noise_value[15:0]
	output logic [gn2d_pkg::NOISE_W-1:0]       m_tdata
);
	import gn2d_pkg::*;

	logic       adv;
	stage_ctl_t ctl_in, ctl_s2;

	logic [IDX_W-1:0]     idx_s2;
	logic [GRAD_W-1:0]    gx_s2, gy_s2;
	logic [PERM_W-1:0]    b00_s2, b10_s2, b01_s2, b11_s2;
	logic [FRAC_BITS-1:0] rx0_s1, ry0_s1, rx0_s2, ry0_s2;
	logic [FRAC_BITS:0]   sx_s5, sy_s5;

	logic                    v_s5;
	logic signed [DOT_W-1:0] d00_s5, d10_s5, d01_s5, d11_s5;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	assign ctl_in.valid = s_tvalid && adv;
	assign ctl_in.cmd   = cmd_t'(s_tuser);

	gn2d_hash #(
		.TABLE_SIZE(TABLE_SIZE),
		.FRAC_BITS(FRAC_BITS)
	) u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl_in     (ctl_in),
		.table_index(s_tdata[IDX_LSB +: IDX_W]),
		.perm_entry (s_tdata[PE_LSB +: PERM_W]),
		.grad_x     (s_tdata[GX_LSB +: GRAD_W]),
		.grad_y     (s_tdata[GY_LSB +: GRAD_W]),
		.coord_x    (s_tdata[CX_LSB +: COORD_W]),
		.coord_y    (s_tdata[CY_LSB +: COORD_W]),
		.rx0_s1     (rx0_s1),
		.ry0_s1     (ry0_s1),
		.ctl_s2     (ctl_s2),
		.idx_s2     (idx_s2),
		.gx_s2      (gx_s2),
		.gy_s2      (gy_s2),
		.b00_s2     (b00_s2),
		.b10_s2     (b10_s2),
		.b01_s2     (b01_s2),
		.b11_s2     (b11_s2),
		.rx0_s2     (rx0_s2),
		.ry0_s2     (ry0_s2)
	);

	gn2d_fade #(
		.FRAC_BITS(FRAC_BITS)
	) u_fade (
		.clk   (clk),
		.adv   (adv),
		.rx0_s1(rx0_s1),
		.ry0_s1(ry0_s1),
		.sx_s5 (sx_s5),
		.sy_s5 (sy_s5)
	);

	gn2d_grad_dot #(
		.TABLE_SIZE(TABLE_SIZE),
		.FRAC_BITS(FRAC_BITS)
	) u_grad_dot (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.ctl_s2(ctl_s2),
		.idx_s2(idx_s2),
		.gx_s2 (gx_s2),
		.gy_s2 (gy_s2),
		.b00_s2(b00_s2),
		.b10_s2(b10_s2),
		.b01_s2(b01_s2),
		.b11_s2(b11_s2),
		.rx0_s2(rx0_s2),
		.ry0_s2(ry0_s2),
		.v_s5  (v_s5),
		.d00_s5(d00_s5),
		.d10_s5(d10_s5),
		.d01_s5(d01_s5),
		.d11_s5(d11_s5)
	);

	gn2d_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_s5     (v_s5),
		.d00_s5   (d00_s5),
		.d10_s5   (d10_s5),
		.d01_s5   (d01_s5),
		.d11_s5   (d11_s5),
		.sx_s5    (sx_s5),
		.sy_s5    (sy_s5),
		.out_valid(m_tvalid),
		.out_noise(m_tdata)
	);

endmodule

// ----- design/gn2d_hash.sv -----
// Lattice split and two-level permutation hash (stages 1 and 2).
module gn2d_hash #(
	parameter int TABLE_SIZE = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  gn2d_pkg::stage_ctl_t             ctl_in,
	input  logic [gn2d_pkg::IDX_W-1:0]       table_index,
	input  logic [gn2d_pkg::PERM_W-1:0]      perm_entry,
	input  logic [gn2d_pkg::GRAD_W-1:0]      grad_x,
	input  logic [gn2d_pkg::GRAD_W-1:0]      grad_y,
	input  logic [gn2d_pkg::COORD_W-1:0]     coord_x,
	input  logic [gn2d_pkg::COORD_W-1:0]     coord_y,
	output logic [FRAC_BITS-1:0]             rx0_s1,
	output logic [FRAC_BITS-1:0]             ry0_s1,
	output gn2d_pkg::stage_ctl_t             ctl_s2,
	output logic [gn2d_pkg::IDX_W-1:0]       idx_s2,
	output logic [gn2d_pkg::GRAD_W-1:0]      gx_s2,
	output logic [gn2d_pkg::GRAD_W-1:0]      gy_s2,
	output logic [gn2d_pkg::PERM_W-1:0]      b00_s2,
	output logic [gn2d_pkg::PERM_W-1:0]      b10_s2,
	output logic [gn2d_pkg::PERM_W-1:0]      b01_s2,
	output logic [gn2d_pkg::PERM_W-1:0]      b11_s2,
	output logic [FRAC_BITS-1:0]             rx0_s2,
	output logic [FRAC_BITS-1:0]             ry0_s2
);
	import gn2d_pkg::*;

	localparam int IW = $clog2(TABLE_SIZE);

	// Three copies of the permutation table: one for the stage-1 reads, two for
	// the four stage-2 reads; each copy is written when a load passes the stage
	// that reads it, so item order holds.
	logic [PERM_W-1:0] perm_a_q [TABLE_SIZE];
	logic [PERM_W-1:0] perm_b_q [TABLE_SIZE];
	logic [PERM_W-1:0] perm_c_q [TABLE_SIZE];

	logic signed [COORD_W-1:0] cell_x, cell_y;
	logic [IW-1:0]             bx0, bx1;

	stage_ctl_t        ctl_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [PERM_W-1:0] pe_s1;
	logic [GRAD_W-1:0] gx_s1, gy_s1;
	logic [IW-1:0]     by0_s1, by1;
	logic [PERM_W-1:0] i_s1, j_s1;
	logic [IW-1:0]     a_i0, a_i1, a_j0, a_j1;

	assign cell_x = $signed(coord_x) >>> FRAC_BITS;
	assign cell_y = $signed(coord_y) >>> FRAC_BITS;
	assign bx0    = cell_x[IW-1:0];
	assign bx1    = bx0 + IW'(1);

	assign by1  = by0_s1 + IW'(1);
	assign a_i0 = IW'(i_s1) + by0_s1;
	assign a_i1 = IW'(i_s1) + by1;
	assign a_j0 = IW'(j_s1) + by0_s1;
	assign a_j1 = IW'(j_s1) + by1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= table_index;
			pe_s1  <= perm_entry;
			gx_s1  <= grad_x;
			gy_s1  <= grad_y;
			rx0_s1 <= coord_x[FRAC_BITS-1:0];
			ry0_s1 <= coord_y[FRAC_BITS-1:0];
			by0_s1 <= cell_y[IW-1:0];
			i_s1   <= perm_a_q[bx0];
			j_s1   <= perm_a_q[bx1];
			if (ctl_in.valid && ctl_in.cmd == CMD_LOAD_PERM) begin
				perm_a_q[IW'(table_index)] <= perm_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2 <= idx_s1;
			gx_s2  <= gx_s1;
			gy_s2  <= gy_s1;
			rx0_s2 <= rx0_s1;
			ry0_s2 <= ry0_s1;
			b00_s2 <= perm_b_q[a_i0];
			b01_s2 <= perm_b_q[a_i1];
			b10_s2 <= perm_c_q[a_j0];
			b11_s2 <= perm_c_q[a_j1];
			if (ctl_s1.valid && ctl_s1.cmd == CMD_LOAD_PERM) begin
				perm_b_q[IW'(idx_s1)] <= pe_s1;
				perm_c_q[IW'(idx_s1)] <= pe_s1;
			end
		end
	end

endmodule

// ----- design/gn2d_fade.sv -----
// Smoothstep fade curve s = t*t*(3-2t) for both axes (stages 2 to 5).
module gn2d_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [FRAC_BITS-1:0] rx0_s1,
	input  logic [FRAC_BITS-1:0] ry0_s1,
	output logic [FRAC_BITS:0]   sx_s5,
	output logic [FRAC_BITS:0]   sy_s5
);
	localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS + 2)'(3) << FRAC_BITS;

	logic [FRAC_BITS-1:0]     rx_s2, ry_s2;
	logic [2*FRAC_BITS-1:0]   ttx_s2, tty_s2;
	logic [FRAC_BITS+1:0]     kx, ky;
	logic [2*FRAC_BITS+1:0]   akx_s3, aky_s3;
	logic [FRAC_BITS:0]       sx_s4, sy_s4;

	assign kx = THREE - {1'b0, rx_s2, 1'b0};
	assign ky = THREE - {1'b0, ry_s2, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s2  <= rx0_s1;
			ry_s2  <= ry0_s1;
			ttx_s2 <= rx0_s1 * rx0_s1;
			tty_s2 <= ry0_s1 * ry0_s1;
			akx_s3 <= ttx_s2[2*FRAC_BITS-1:FRAC_BITS] * kx;
			aky_s3 <= tty_s2[2*FRAC_BITS-1:FRAC_BITS] * ky;
			sx_s4  <= akx_s3[2*FRAC_BITS:FRAC_BITS];
			sy_s4  <= aky_s3[2*FRAC_BITS:FRAC_BITS];
			sx_s5  <= sx_s4;
			sy_s5  <= sy_s4;
		end
	end

endmodule

// ----- design/gn2d_grad_dot.sv -----
// Gradient table lookup and corner dot products (stages 3 to 5).
module gn2d_grad_dot #(
	parameter int TABLE_SIZE = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  gn2d_pkg::stage_ctl_t                ctl_s2,
	input  logic [gn2d_pkg::IDX_W-1:0]          idx_s2,
	input  logic [gn2d_pkg::GRAD_W-1:0]         gx_s2,
	input  logic [gn2d_pkg::GRAD_W-1:0]         gy_s2,
	input  logic [gn2d_pkg::PERM_W-1:0]         b00_s2,
	input  logic [gn2d_pkg::PERM_W-1:0]         b10_s2,
	input  logic [gn2d_pkg::PERM_W-1:0]         b01_s2,
	input  logic [gn2d_pkg::PERM_W-1:0]         b11_s2,
	input  logic [FRAC_BITS-1:0]                rx0_s2,
	input  logic [FRAC_BITS-1:0]                ry0_s2,
	output logic                                v_s5,
	output logic signed [gn2d_pkg::DOT_W-1:0]   d00_s5,
	output logic signed [gn2d_pkg::DOT_W-1:0]   d10_s5,
	output logic signed [gn2d_pkg::DOT_W-1:0]   d01_s5,
	output logic signed [gn2d_pkg::DOT_W-1:0]   d11_s5
);
	import gn2d_pkg::*;

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int PW = FRAC_BITS + GRAD_W + 1;
	localparam int SW = PW + 1;

	// Two copies: each serves two of the four corner reads. {grad_y, grad_x}
	logic [2*GRAD_W-1:0] grad_a_q [TABLE_SIZE];
	logic [2*GRAD_W-1:0] grad_b_q [TABLE_SIZE];

	logic                ev_s3, ev_s4;
	logic [2*GRAD_W-1:0] g00_s3, g10_s3, g01_s3, g11_s3;
	logic [FRAC_BITS-1:0] rx0_s3, ry0_s3;

	logic signed [FRAC_BITS:0] rx_lo, rx_hi, ry_lo, ry_hi;
	logic signed [PW-1:0] p00x_s4, p00y_s4, p10x_s4, p10y_s4;
	logic signed [PW-1:0] p01x_s4, p01y_s4, p11x_s4, p11y_s4;
	logic signed [SW-1:0] sum00, sum10, sum01, sum11;

	// Offset from the far corner is r - 1.0, i.e. the fraction with a set sign bit
	assign rx_lo = $signed({1'b0, rx0_s3});
	assign rx_hi = $signed({1'b1, rx0_s3});
	assign ry_lo = $signed({1'b0, ry0_s3});
	assign ry_hi = $signed({1'b1, ry0_s3});

	assign sum00 = SW'(p00x_s4) + SW'(p00y_s4);
	assign sum10 = SW'(p10x_s4) + SW'(p10y_s4);
	assign sum01 = SW'(p01x_s4) + SW'(p01y_s4);
	assign sum11 = SW'(p11x_s4) + SW'(p11y_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s3 <= 1'b0;
			ev_s4 <= 1'b0;
			v_s5  <= 1'b0;
		end else if (adv) begin
			ev_s3 <= ctl_s2.valid && ctl_s2.cmd == CMD_EVAL;
			ev_s4 <= ev_s3;
			v_s5  <= ev_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx0_s3 <= rx0_s2;
			ry0_s3 <= ry0_s2;
			g00_s3 <= grad_a_q[IW'(b00_s2)];
			g10_s3 <= grad_a_q[IW'(b10_s2)];
			g01_s3 <= grad_b_q[IW'(b01_s2)];
			g11_s3 <= grad_b_q[IW'(b11_s2)];
			if (ctl_s2.valid && ctl_s2.cmd == CMD_LOAD_GRAD) begin
				grad_a_q[IW'(idx_s2)] <= {gy_s2, gx_s2};
				grad_b_q[IW'(idx_s2)] <= {gy_s2, gx_s2};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p00x_s4 <= rx_lo * $signed(g00_s3[GRAD_W-1:0]);
			p00y_s4 <= ry_lo * $signed(g00_s3[2*GRAD_W-1:GRAD_W]);
			p10x_s4 <= rx_hi * $signed(g10_s3[GRAD_W-1:0]);
			p10y_s4 <= ry_lo * $signed(g10_s3[2*GRAD_W-1:GRAD_W]);
			p01x_s4 <= rx_lo * $signed(g01_s3[GRAD_W-1:0]);
			p01y_s4 <= ry_hi * $signed(g01_s3[2*GRAD_W-1:GRAD_W]);
			p11x_s4 <= rx_hi * $signed(g11_s3[GRAD_W-1:0]);
			p11y_s4 <= ry_hi * $signed(g11_s3[2*GRAD_W-1:GRAD_W]);
			d00_s5  <= DOT_W'(sum00 >>> FRAC_BITS);
			d10_s5  <= DOT_W'(sum10 >>> FRAC_BITS);
			d01_s5  <= DOT_W'(sum01 >>> FRAC_BITS);
			d11_s5  <= DOT_W'(sum11 >>> FRAC_BITS);
		end
	end

endmodule

// ----- design/gn2d_blend.sv -----
// Bilinear smoothstep blend, saturation and output register (stages 6 to out).
module gn2d_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               v_s5,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d00_s5,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d10_s5,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d01_s5,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d11_s5,
	input  logic [FRAC_BITS:0]                 sx_s5,
	input  logic [FRAC_BITS:0]                 sy_s5,
	output logic                               out_valid,
	output logic [gn2d_pkg::NOISE_W-1:0]       out_noise
);
	import gn2d_pkg::*;

	localparam int MW = DOT_W + FRAC_BITS + 3;

	logic signed [DOT_W:0]       dx0, dx1, dy;
	logic signed [FRAC_BITS+1:0] sxs, sys;

	logic                     v_s6, v_s7, v_s8;
	logic signed [MW-1:0]     px0_s6, px1_s6, py_s8;
	logic signed [DOT_W-1:0]  d00_s6, d01_s6, a_s7, b_s7, a_s8;
	logic [FRAC_BITS:0]       sy_s6, sy_s7;
	logic signed [DOT_W-1:0]  r;
	logic [NOISE_W-1:0]       sat;

	logic                     out_valid_q;
	logic [NOISE_W-1:0]       noise_q;

	assign dx0 = (DOT_W + 1)'(d10_s5) - (DOT_W + 1)'(d00_s5);
	assign dx1 = (DOT_W + 1)'(d11_s5) - (DOT_W + 1)'(d01_s5);
	assign sxs = $signed({1'b0, sx_s5});
	assign dy  = (DOT_W + 1)'(b_s7) - (DOT_W + 1)'(a_s7);
	assign sys = $signed({1'b0, sy_s7});

	// Blend result lies between its two ends, so it fits DOT_W
	assign r = a_s8 + DOT_W'(py_s8 >>> FRAC_BITS);

	always_comb begin
		if (r > SAT_HI) begin
			sat = NOISE_W'(SAT_HI);
		end else if (r < SAT_LO) begin
			sat = NOISE_W'(SAT_LO);
		end else begin
			sat = NOISE_W'(r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px0_s6  <= dx0 * sxs;
			px1_s6  <= dx1 * sxs;
			d00_s6  <= d00_s5;
			d01_s6  <= d01_s5;
			sy_s6   <= sy_s5;
			a_s7    <= d00_s6 + DOT_W'(px0_s6 >>> FRAC_BITS);
			b_s7    <= d01_s6 + DOT_W'(px1_s6 >>> FRAC_BITS);
			sy_s7   <= sy_s6;
			py_s8   <= dy * sys;
			a_s8    <= a_s7;
			noise_q <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_noise = noise_q;

	a_result_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s8 |=> out_valid)
		else $error("finished item did not reach the output register");

	a_bubble_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !v_s8 |=> !out_valid)
		else $error("output valid without an item behind it");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s8) && $stable(a_s8) && $stable(py_s8))
		else $error("last stage changed during a stall");

endmodule
